[rtl/core/free_hole_fit_allocator_unit_macros.svh]
// Assertion macros shared by the free hole allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FREE_HOLE_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_HOLE_FIT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FHFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fhfa_pkg.sv]
// Types, constants and the ordering function of the free hole allocator.
// Depends on nothing; used by every module of the block.
`default_nettype none

package fhfa_pkg;

    localparam int MAX_HOLES = 64;
    localparam int CNT_W     = $clog2(MAX_HOLES + 1);
    localparam int SIZE_W    = 32;
    localparam int OFS_W     = 31;
    localparam int STRAT_W   = 2;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIT    = 1'b1;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_GRANTED = 2'd1,
        ST_NO_FIT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] block_size;
        logic [OFS_W-1:0]  block_offset;
    } t_in_word;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] granted_offset;
    } t_out_word;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  offset;
    } t_hole;

    typedef enum logic [2:0] {
        OP_KEEP,
        OP_NEW,
        OP_LEFT,
        OP_RIGHT,
        OP_SPLIT
    } t_cell_op;

    typedef struct packed {
        logic hit;
        logic eq;
        logic before_key;
        logic right_before;
    } t_cell_flag;

    function automatic logic goes_before(input logic desc, input t_hole a, input t_hole b);
        logic res;
        if (a.size != b.size) begin
            res = desc ? (a.size > b.size) : (a.size < b.size);
        end else begin
            res = a.offset < b.offset;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/fhfa_cell.sv]
// One storage cell of the hole row: holds one hole and compares it with the key and its right neighbor.
// Depends on fhfa_pkg.
`default_nettype none

module fhfa_cell (
    input  wire logic                i_clk,
    input  wire fhfa_pkg::t_cell_op  i_op,
    input  wire logic                i_desc,
    input  wire fhfa_pkg::t_hole     i_key,
    input  wire fhfa_pkg::t_hole     i_left,
    input  wire fhfa_pkg::t_hole     i_right,
    output fhfa_pkg::t_hole          o_hole,
    output fhfa_pkg::t_cell_flag     o_flag
);
    import fhfa_pkg::*;

    t_hole r_hole;
    t_hole n_hole;

    always_comb begin
        n_hole = r_hole;
        case (i_op)
            OP_KEEP:  n_hole = r_hole;
            OP_NEW:   n_hole = i_key;
            OP_LEFT:  n_hole = i_left;
            OP_RIGHT: n_hole = i_right;
            OP_SPLIT: begin
                n_hole.size   = r_hole.size - i_key.size;
                n_hole.offset = r_hole.offset + i_key.size[OFS_W-1:0];
            end
            default:  n_hole = r_hole;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hole <= n_hole;
    end

    assign o_hole = r_hole;
    assign o_flag = '{
        hit:          r_hole.size >= i_key.size,
        eq:           r_hole.size == i_key.size,
        before_key:   goes_before(i_desc, r_hole, i_key),
        right_before: goes_before(i_desc, i_right, r_hole)
    };

endmodule

`default_nettype wire

[rtl/core/free_hole_fit_allocator_unit.sv]
// Top level of the free hole allocator: control sequencer over a row of hole cells.
// Depends on fhfa_pkg, fhfa_cell and free_hole_fit_allocator_unit_macros.svh.
// After accept an insert passes the start and result states, a fit on an ordered list start, grant
// and result; unordered lists under best or worst fit add odd-even sort passes, plus match for a fit.
// One word at a time; the result waits in the result state while the output register is still full.
// Reset clears the hole count and the strategy; cell contents are not cleared.
`default_nettype none
`include "free_hole_fit_allocator_unit_macros.svh"

module free_hole_fit_allocator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fhfa_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fhfa_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fhfa_pkg::STRAT_W-1:0]    i_cfg_data
);
    import fhfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SORT,
        S_MATCH,
        S_GRANT,
        S_RESULT
    } t_state;

    t_state               r_state;
    logic [STRAT_W-1:0]   r_strategy;
    logic [CNT_W-1:0]     r_count;
    logic                 r_sorted;
    logic                 r_mode;
    t_hole                r_key;
    logic [CNT_W-1:0]     r_phase;
    logic [MAX_HOLES-1:0] r_hit;
    logic [MAX_HOLES-1:0] r_eq;
    t_status              r_status;
    logic [OFS_W-1:0]     r_granted;
    logic                 r_out_valid;
    t_out_word            r_out_word;

    t_hole                w_hole  [MAX_HOLES];
    t_hole                w_left  [MAX_HOLES];
    t_hole                w_right [MAX_HOLES];
    t_cell_flag           w_flag  [MAX_HOLES];
    t_cell_op             w_op    [MAX_HOLES];

    logic [MAX_HOLES-1:0] w_valid;
    logic [MAX_HOLES-1:0] w_hit;
    logic [MAX_HOLES-1:0] w_eq;
    logic [MAX_HOLES-1:0] w_before_key;
    logic [MAX_HOLES-1:0] w_left_before;
    logic [MAX_HOLES-1:0] w_swap;
    logic [MAX_HOLES-1:0] w_swap_left;
    logic [MAX_HOLES-1:0] w_first;
    logic [MAX_HOLES-1:0] w_past;
    logic                 w_any;
    logic                 w_exact;
    logic [OFS_W-1:0]     w_granted;
    logic                 w_sort_on;
    logic                 w_desc;
    logic                 w_full;
    logic [CNT_W-1:0]     n_phase;

    assign w_sort_on = (r_strategy == STRAT_BEST) || (r_strategy == STRAT_WORST);
    assign w_desc    = r_strategy == STRAT_WORST;
    assign w_full    = r_count == CNT_W'(MAX_HOLES);
    assign n_phase   = r_phase + CNT_W'(1);

    genvar g;
    generate
        for (g = 0; g < MAX_HOLES; g++) begin : g_cell
            fhfa_cell u_cell (
                .i_clk   (i_clk),
                .i_op    (w_op[g]),
                .i_desc  (w_desc),
                .i_key   (r_key),
                .i_left  (w_left[g]),
                .i_right (w_right[g]),
                .o_hole  (w_hole[g]),
                .o_flag  (w_flag[g])
            );
        end
    endgenerate

    always_comb begin
        w_left[0]             = r_key;
        w_right[MAX_HOLES-1]  = r_key;
        for (int j = 1; j < MAX_HOLES; j++) begin
            w_left[j]    = w_hole[j-1];
            w_right[j-1] = w_hole[j];
        end
        for (int j = 0; j < MAX_HOLES; j++) begin
            w_valid[j]      = CNT_W'(j) < r_count;
            w_hit[j]        = w_flag[j].hit & w_valid[j];
            w_eq[j]         = w_flag[j].eq;
            w_before_key[j] = w_flag[j].before_key & w_valid[j];
        end
        w_swap[MAX_HOLES-1] = 1'b0;
        for (int j = 0; j < MAX_HOLES - 1; j++) begin
            w_swap[j] = (j[0] == r_phase[0]) & w_valid[j+1] & w_flag[j].right_before;
        end
    end

    assign w_left_before = {w_before_key[MAX_HOLES-2:0], 1'b1};
    assign w_swap_left   = {w_swap[MAX_HOLES-2:0], 1'b0};

    assign w_first = r_hit & (~r_hit + MAX_HOLES'(1));
    assign w_past  = ~(w_first | (w_first - MAX_HOLES'(1)));
    assign w_any   = |r_hit;
    assign w_exact = |(w_first & r_eq);

    always_comb begin
        w_granted = '0;
        for (int j = 0; j < MAX_HOLES; j++) begin
            w_granted = w_granted | (w_hole[j].offset & {OFS_W{w_first[j]}});
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_HOLES; j++) begin
            w_op[j] = OP_KEEP;
            case (r_state)
                S_START: begin
                    if (r_mode == MODE_INSERT && !w_full) begin
                        if (w_sort_on && r_sorted) begin
                            if (w_before_key[j]) begin
                                w_op[j] = OP_KEEP;
                            end else if (w_left_before[j]) begin
                                w_op[j] = OP_NEW;
                            end else begin
                                w_op[j] = OP_LEFT;
                            end
                        end else if (CNT_W'(j) == r_count) begin
                            w_op[j] = OP_NEW;
                        end
                    end
                end
                S_SORT: begin
                    if (w_swap[j]) begin
                        w_op[j] = OP_RIGHT;
                    end else if (w_swap_left[j]) begin
                        w_op[j] = OP_LEFT;
                    end
                end
                S_GRANT: begin
                    if (w_any) begin
                        if (w_exact) begin
                            if (w_first[j] | w_past[j]) begin
                                w_op[j] = OP_RIGHT;
                            end
                        end else if (w_first[j]) begin
                            w_op[j] = OP_SPLIT;
                        end
                    end
                end
                default: w_op[j] = OP_KEEP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_strategy  <= STRAT_FIRST;
            r_count     <= '0;
            r_sorted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_strategy <= i_cfg_data;
                r_sorted   <= 1'b0;
            end
            if (r_out_valid && i_out_ready && r_state != S_RESULT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode       <= i_in_word.mode;
                        r_key.size   <= i_in_word.block_size;
                        r_key.offset <= i_in_word.block_offset;
                        r_state      <= S_START;
                    end
                end
                S_START: begin
                    r_hit     <= w_hit;
                    r_eq      <= w_eq;
                    r_phase   <= '0;
                    r_granted <= '0;
                    if (r_mode == MODE_INSERT) begin
                        if (w_full) begin
                            r_status <= ST_FULL;
                            r_state  <= S_RESULT;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                            if (w_sort_on && !r_sorted) begin
                                r_state <= S_SORT;
                            end else begin
                                r_status <= ST_STORED;
                                r_state  <= S_RESULT;
                            end
                        end
                    end else if (w_sort_on && !r_sorted) begin
                        r_state <= S_SORT;
                    end else begin
                        r_state <= S_GRANT;
                    end
                end
                S_SORT: begin
                    r_phase <= n_phase;
                    if (n_phase >= r_count) begin
                        r_sorted <= 1'b1;
                        if (r_mode == MODE_INSERT) begin
                            r_status <= ST_STORED;
                            r_state  <= S_RESULT;
                        end else begin
                            r_state <= S_MATCH;
                        end
                    end
                end
                S_MATCH: begin
                    r_hit   <= w_hit;
                    r_eq    <= w_eq;
                    r_state <= S_GRANT;
                end
                S_GRANT: begin
                    if (w_any) begin
                        r_status  <= ST_GRANTED;
                        r_granted <= w_granted;
                        if (w_exact) begin
                            r_count <= r_count - CNT_W'(1);
                        end else begin
                            r_sorted <= 1'b0;
                        end
                    end else begin
                        r_status  <= ST_NO_FIT;
                        r_granted <= '0;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid               <= 1'b1;
                        r_out_word.status         <= r_status;
                        r_out_word.granted_offset <= r_granted;
                        r_state                   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = r_state == S_IDLE;

    `FHFA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_HOLES),
        "Hole count exceeds the list capacity.")
    `FHFA_ASSERT_NOW(a_single_grant, i_clk, i_rst_n, r_state == S_GRANT, $onehot0(w_first),
        "More than one hole selected for a grant.")
    `FHFA_ASSERT_NEXT(a_exact_removes, i_clk, i_rst_n, r_state == S_GRANT && w_any && w_exact,
        r_count == $past(r_count) - CNT_W'(1), "Exact fit did not remove a hole.")
    `FHFA_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n,
        r_state == S_START && r_mode == MODE_INSERT && w_full,
        r_count == $past(r_count) && r_state == S_RESULT, "Insert into a full list changed it.")
    `FHFA_ASSERT_NOW(a_offset_zero, i_clk, i_rst_n, o_out_valid,
        o_out_word.status == ST_GRANTED || o_out_word.granted_offset == '0,
        "Nonzero offset in a word that grants nothing.")

endmodule

`default_nettype wire
